/* src/pttl_pkg.sv */
package pttl_pkg;

    // Operation codes carried in the func field
    localparam logic [1:0] FUNC_TAINT = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    // Result status codes
    localparam logic [2:0] STS_REFRESHED = 3'd0;
    localparam logic [2:0] STS_INSERTED  = 3'd1;
    localparam logic [2:0] STS_FULL      = 3'd2;
    localparam logic [2:0] STS_RESERVED  = 3'd3;
    localparam logic [2:0] STS_CLEARED   = 3'd4;
    localparam logic [2:0] STS_NOT_FOUND = 3'd5;
    localparam logic [2:0] STS_EXPIRED   = 3'd6;
    localparam logic [2:0] STS_LIVE      = 3'd7;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TTL        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_B = 2'd2;

    localparam logic [63:0] TTL_RESET        = 64'd18000000000;
    localparam logic [31:0] RESERVED_A_RESET = 32'd0;
    localparam logic [31:0] RESERVED_B_RESET = 32'd4;

    // Bits of the id above the two dropped low bits
    localparam int unsigned KEY_W = 30;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] proc_id;
        logic [31:0] category_bits;
        logic [63:0] time_now;
    } in_item_t;

    typedef struct packed {
        logic       is_tainted;
        logic [2:0] status;
    } out_item_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] owner;
        logic [31:0] cats;
        logic [63:0] stamp;
    } way_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_REM,
        ST_READ,
        ST_EVAL
    } pttl_state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic rem_step;
        logic commit;
        logic clr_step;
    } pttl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_busy;
    } pttl_sts_t;

endpackage

/* src/pttl_ram.sv */
module pttl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/pttl_ctrl.sv */
module pttl_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output pttl_pkg::pttl_cmd_t  cmd,
    input  pttl_pkg::pttl_sts_t  sts
);
    import pttl_pkg::*;

    pttl_state_t state_reg;
    pttl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                state_next   = ST_REM;
            end
            ST_REM: begin
                cmd.rem_step = 1'b1;
                state_next   = ST_READ;
            end
            ST_READ: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                // hold the row until the previous result has left
                if (!sts.out_busy) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

/* src/pttl_dp.sv */
module pttl_dp #(
    parameter int unsigned BUCKET_COUNT    = 64,
    parameter int unsigned WAYS_PER_BUCKET = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  pttl_pkg::in_item_t                s_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pttl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [63:0]                       cfg_data,
    input  pttl_pkg::pttl_cmd_t               cmd,
    output pttl_pkg::pttl_sts_t               sts,
    output logic                              m_valid,
    input  logic                              m_ready,
    output pttl_pkg::out_item_t               m_data
);
    import pttl_pkg::*;

    localparam int unsigned IDX_W   = $clog2(BUCKET_COUNT);
    localparam int unsigned WAY_W   = (WAYS_PER_BUCKET > 1) ? $clog2(WAYS_PER_BUCKET) : 1;
    localparam int unsigned ROW_W   = $bits(way_t) * WAYS_PER_BUCKET;
    // exact floor(x / BUCKET_COUNT) for x below 2^KEY_W by a reciprocal multiply
    localparam int unsigned SHIFT   = KEY_W + IDX_W;
    localparam int unsigned MAG_W   = KEY_W + 1;
    localparam int unsigned PROD_W  = KEY_W + MAG_W;
    localparam int unsigned QB_W    = KEY_W + IDX_W + 1;
    localparam logic [63:0] MAGIC64 =
        ((64'd1 << SHIFT) + 64'(BUCKET_COUNT) - 64'd1) / BUCKET_COUNT;
    localparam logic [MAG_W-1:0] MAGIC   = MAGIC64[MAG_W-1:0];
    localparam logic [IDX_W:0]   BKT     = (IDX_W + 1)'(BUCKET_COUNT);
    localparam logic [IDX_W-1:0] LAST_BKT = IDX_W'(BUCKET_COUNT - 1);

    // configuration
    logic [63:0] ttl_reg;
    logic [31:0] rsv_a_reg;
    logic [31:0] rsv_b_reg;

    // current item
    in_item_t          item_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [IDX_W-1:0]  bucket_reg;
    logic [IDX_W-1:0]  clr_cnt_reg;

    // result register
    logic      m_valid_reg;
    out_item_t m_data_reg;

    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] quot;
    logic [QB_W-1:0]  qb;
    logic [KEY_W-1:0] rem_full;

    way_t [WAYS_PER_BUCKET-1:0] row_rd;
    way_t [WAYS_PER_BUCKET-1:0] row_new;
    logic [ROW_W-1:0]           ram_rdata;
    logic [ROW_W-1:0]           ram_wdata;
    logic [IDX_W-1:0]           ram_waddr;
    logic [IDX_W-1:0]           ram_raddr;
    logic                       ram_we;

    logic [WAYS_PER_BUCKET-1:0] hit_vec;
    logic [WAYS_PER_BUCKET-1:0] free_vec;
    logic [WAY_W-1:0]           hit_idx;
    logic [WAY_W-1:0]           free_idx;
    logic                       any_hit;
    logic                       any_free;
    logic [63:0]                age;
    logic                       expired;
    logic                       reserved;
    out_item_t                  result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ttl_reg   <= TTL_RESET;
            rsv_a_reg <= RESERVED_A_RESET;
            rsv_b_reg <= RESERVED_B_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TTL:        ttl_reg   <= cfg_data;
                CFG_RESERVED_A: rsv_a_reg <= cfg_data[31:0];
                CFG_RESERVED_B: rsv_b_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // bucket index = (id >> 2) mod BUCKET_COUNT over two multiply steps
    assign key      = item_reg.proc_id[31:2];
    assign quot     = KEY_W'(prod_reg >> SHIFT);
    assign qb       = QB_W'(quot) * QB_W'(BKT);
    assign rem_full = key - qb[KEY_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
        if (cmd.div_step) begin
            prod_reg <= PROD_W'(key) * PROD_W'(MAGIC);
        end
        if (cmd.rem_step) begin
            bucket_reg <= rem_full[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
        end
    end

    assign sts.clr_last = (clr_cnt_reg == LAST_BKT);
    assign sts.out_busy = m_valid_reg && !m_ready;

    assign row_rd   = ram_rdata;
    assign reserved = (item_reg.proc_id == rsv_a_reg) || (item_reg.proc_id == rsv_b_reg);

    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int w = 0; w < WAYS_PER_BUCKET; w++) begin
            hit_vec[w]  = row_rd[w].valid && (row_rd[w].owner == item_reg.proc_id);
            free_vec[w] = !row_rd[w].valid;
        end
        for (int w = WAYS_PER_BUCKET - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_idx = WAY_W'(w);
            end
            if (free_vec[w]) begin
                free_idx = WAY_W'(w);
            end
        end
    end

    assign any_hit  = |hit_vec;
    assign any_free = |free_vec;
    assign age      = item_reg.time_now - row_rd[hit_idx].stamp;
    assign expired  = age > ttl_reg;

    always_comb begin
        row_new           = row_rd;
        result.is_tainted = 1'b0;
        result.status     = STS_NOT_FOUND;
        case (item_reg.func)
            FUNC_TAINT: begin
                if (reserved) begin
                    result.status = STS_RESERVED;
                end else if (any_hit) begin
                    row_new[hit_idx].stamp = item_reg.time_now;
                    row_new[hit_idx].cats  = row_rd[hit_idx].cats | item_reg.category_bits;
                    result.status          = STS_REFRESHED;
                end else if (any_free) begin
                    row_new[free_idx].valid = 1'b1;
                    row_new[free_idx].owner = item_reg.proc_id;
                    row_new[free_idx].cats  = item_reg.category_bits;
                    row_new[free_idx].stamp = item_reg.time_now;
                    result.status           = STS_INSERTED;
                end else begin
                    result.status = STS_FULL;
                end
            end
            FUNC_CLEAR: begin
                if (any_hit) begin
                    row_new[hit_idx].valid = 1'b0;
                    result.status          = STS_CLEARED;
                end
            end
            FUNC_QUERY: begin
                if (any_hit) begin
                    if (expired) begin
                        row_new[hit_idx].valid = 1'b0;
                        result.status          = STS_EXPIRED;
                    end else begin
                        result.is_tainted = 1'b1;
                        result.status     = STS_LIVE;
                    end
                end
            end
            default: ;
        endcase
    end

    assign ram_we    = cmd.clr_step || cmd.commit;
    assign ram_waddr = cmd.clr_step ? clr_cnt_reg : bucket_reg;
    assign ram_wdata = cmd.clr_step ? '0 : ROW_W'(row_new);
    assign ram_raddr = bucket_reg;

    pttl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUCKET_COUNT)
    ) u_row_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_commit_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid_reg)
        else $error("result register not loaded after commit");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !(m_valid_reg && !m_ready))
        else $error("pending result overwritten");

    a_taint_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.is_tainted == (m_data_reg.status == STS_LIVE)))
        else $error("tainted flag disagrees with status");

    a_no_clear_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_step |-> !cmd.commit && !cmd.load)
        else $error("item activity during clearing pass");
`endif

endmodule

/* src/pid_taint_table_with_ttl.sv */
// Channel   Direction  Handshake             Payload
// s_        in         s_valid / s_ready     s_data   (func, proc_id, category_bits, time_now)
// m_        out        m_valid / m_ready     m_data   (is_tainted, status)
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data (ttl, reserved ids)
//
// Each item passes accept, reciprocal multiply, remainder, bucket row read,
// evaluate and write back. The two-step bucket hash and the registered
// row read set the pace; items never overlap.
// After reset a clearing pass writes an empty row to each of the BUCKET_COUNT
// buckets with s_ready low; configuration writes are taken throughout (cfg_ready is high).
// A finished result waits in the output register; the next item is accepted
// meanwhile and only its write back holds while that beat is still unsent.
module pid_taint_table_with_ttl #(
    parameter int unsigned BUCKET_COUNT    = 64,
    parameter int unsigned WAYS_PER_BUCKET = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // item channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  pttl_pkg::in_item_t             s_data,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output pttl_pkg::out_item_t            m_data,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pttl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                    cfg_data
);
    import pttl_pkg::*;

    pttl_cmd_t cmd;
    pttl_sts_t sts;

    // sequence the clearing pass and each item's steps
    pttl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // bucket hashing, row storage, hit/free search, aging and result register
    pttl_dp #(
        .BUCKET_COUNT    (BUCKET_COUNT),
        .WAYS_PER_BUCKET (WAYS_PER_BUCKET)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

/* test/tb.sv */
module tb;
    import pttl_pkg::*;

    localparam int unsigned TBL_BUCKETS = 64;
    localparam int unsigned TBL_WAYS    = 4;
    localparam int unsigned TBL_SLOTS   = TBL_BUCKETS * TBL_WAYS;

    // The package names only the three real operations; code 3 is unused
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_item_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_item_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0] cfg_data  = '0;

    // Shadow copy of the table and of the registers
    logic        tbl_valid [0:TBL_SLOTS-1];
    logic [31:0] tbl_owner [0:TBL_SLOTS-1];
    logic [31:0] tbl_cats  [0:TBL_SLOTS-1];
    logic [63:0] tbl_stamp [0:TBL_SLOTS-1];
    logic [63:0] ttl_limit = TTL_RESET;
    logic [31:0] rsv_a     = RESERVED_A_RESET;
    logic [31:0] rsv_b     = RESERVED_B_RESET;

    in_item_t    pending_q[$];     // beats waiting to be offered
    out_item_t   status_due_q[$];  // predicted results, oldest first
    logic [31:0] id_pool[$];       // ids crowded into two buckets
    logic [63:0] tick_now;         // running time base of the random part
    logic [63:0] tick_step_max;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic        hold_req       = 1'b0;  // start one long receiver hold
    int          hold_left      = 0;     // cycles the receiver still holds off
    logic        recv_hold;
    int          mismatch_count = 0;
    int          result_no      = 0;

    pid_taint_table_with_ttl #(
        .BUCKET_COUNT    (TBL_BUCKETS),
        .WAYS_PER_BUCKET (TBL_WAYS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    // Work out the result of one accepted beat and apply it to the shadow table.
    function automatic out_item_t predict_taint_result(in_item_t it);
        int        base;
        int        hit;
        out_item_t res;
        logic [63:0] age;
        base = int'((it.proc_id >> 2) % TBL_BUCKETS) * TBL_WAYS;
        hit  = -1;
        res.is_tainted = 1'b0;
        res.status     = STS_NOT_FOUND;
        // Lookup: only valid ways can match, so stale owners never count
        for (int w = 0; w < TBL_WAYS; w++) begin
            if (hit < 0 && tbl_valid[base + w] && tbl_owner[base + w] == it.proc_id) begin
                hit = base + w;
            end
        end
        case (it.func)
            FUNC_TAINT: begin
                if (it.proc_id == rsv_a || it.proc_id == rsv_b) begin
                    res.status = STS_RESERVED;
                end else if (hit >= 0) begin
                    // Refresh even when the entry has already expired
                    tbl_stamp[hit] = it.time_now;
                    tbl_cats[hit]  = tbl_cats[hit] | it.category_bits;
                    res.status     = STS_REFRESHED;
                end else begin
                    // Fill the lowest free way; drop the insert if none is left
                    res.status = STS_FULL;
                    for (int w = 0; w < TBL_WAYS; w++) begin
                        if (res.status == STS_FULL && !tbl_valid[base + w]) begin
                            tbl_valid[base + w] = 1'b1;
                            tbl_owner[base + w] = it.proc_id;
                            tbl_cats[base + w]  = it.category_bits;
                            tbl_stamp[base + w] = it.time_now;
                            res.status          = STS_INSERTED;
                        end
                    end
                end
            end
            FUNC_CLEAR: begin
                if (hit >= 0) begin
                    tbl_valid[hit] = 1'b0;
                    res.status     = STS_CLEARED;
                end
            end
            FUNC_QUERY: begin
                if (hit >= 0) begin
                    // Age wraps modulo 2^64
                    age = it.time_now - tbl_stamp[hit];
                    if (age > ttl_limit) begin
                        tbl_valid[hit] = 1'b0;
                        res.status     = STS_EXPIRED;
                    end else begin
                        res.is_tainted = 1'b1;
                        res.status     = STS_LIVE;
                    end
                end
            end
            default: begin
                // Unused code: no change, reported as not found
            end
        endcase
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic in_item_t make_item(logic [1:0] func, logic [31:0] id,
                                           logic [31:0] cats, logic [63:0] stamp);
        in_item_t it;
        it.func          = func;
        it.proc_id       = id;
        it.category_bits = cats;
        it.time_now      = stamp;
        return it;
    endfunction

    // Mostly pool ids at a steadily advancing time; now and then a stray id,
    // a reserved id or a wild time stamp.
    function automatic in_item_t random_item();
        in_item_t    it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)      it.func = FUNC_TAINT;
        else if (pick < 65) it.func = FUNC_CLEAR;
        else if (pick < 95) it.func = FUNC_QUERY;
        else                it.func = FUNC_UNUSED;
        pick = $urandom_range(0, 99);
        if (pick < 82)      it.proc_id = id_pool[$urandom_range(0, id_pool.size() - 1)];
        else if (pick < 90) it.proc_id = $urandom_range(0, 1) ? rsv_a : rsv_b;
        else                it.proc_id = $urandom;
        it.category_bits = $urandom;
        tick_now = tick_now + rand64() % (tick_step_max + 64'd1);
        it.time_now = ($urandom_range(0, 99) < 3) ? rand64() : tick_now;
        return it;
    endfunction

    // Crowd five ids into each of two buckets so that ways run out.
    task automatic build_id_pool();
        logic [5:0] bucket;
        id_pool.delete();
        for (int b = 0; b < 2; b++) begin
            bucket = 6'($urandom_range(0, TBL_BUCKETS - 1));
            for (int k = 0; k < 5; k++) begin
                id_pool.push_back(($urandom & ~32'h0000_00FC) | (32'(bucket) << 2));
            end
        end
    endtask

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch on result %0d: %s", $realtime, result_no, what);
        mismatch_count++;
    endtask

    // Write one register over the config channel, then mirror it.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TTL:        ttl_limit = value;
            CFG_RESERVED_A: rsv_a     = value[31:0];
            CFG_RESERVED_B: rsv_b     = value[31:0];
            default:        ;
        endcase
        @(negedge aclk);
    endtask

    // Hold the sender until every beat is out and every result is back.
    task automatic wait_all_results();
        do @(negedge aclk);
        while (pending_q.size() != 0 || s_valid || status_due_q.size() != 0);
        repeat (8) @(negedge aclk);
    endtask

    task automatic run_random(int count, int send_idle, int recv_stall,
                              logic [63:0] step_max);
        send_idle_pct  = send_idle;
        recv_stall_pct = recv_stall;
        tick_step_max  = step_max;
        for (int n = 0; n < count; n++) pending_q.push_back(random_item());
        wait_all_results();
    endtask

    // Long receiver hold: count the cycles down once a hold is requested.
    assign recv_hold = (hold_left != 0);

    always @(posedge aclk) begin : hold_receiver
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req) begin
            hold_left <= 300;
        end
    end

    // Driver: offer the next beat, hold it until taken, predict on acceptance.
    always @(posedge aclk) begin : drive_items
        logic taken;
        taken = s_valid && s_ready;
        if (taken) status_due_q.push_back(predict_taint_result(s_data));
        if (!s_valid || taken) begin
            if (aresetn && pending_q.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                s_data  <= pending_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: stall at random, compare each result beat with the oldest prediction.
    always @(posedge aclk) begin : check_results
        out_item_t want;
        m_ready <= !recv_hold && ($urandom_range(0, 99) >= recv_stall_pct);
        if (m_valid && m_ready) begin
            if (status_due_q.size() == 0) begin
                report_mismatch($sformatf("unexpected beat status %0d", m_data.status));
            end else begin
                want = status_due_q.pop_front();
                if (m_data.is_tainted !== want.is_tainted)
                    report_mismatch($sformatf("is_tainted %b, want %b",
                                              m_data.is_tainted, want.is_tainted));
                if (m_data.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              m_data.status, want.status));
            end
            result_no++;
        end
    end

    // Watchdog: a hung handshake ends the run.
    initial begin
        #3000000;
        $display("FAIL");
        $finish;
    end

    initial begin
        for (int i = 0; i < TBL_SLOTS; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_owner[i] = '0;
            tbl_cats[i]  = '0;
            tbl_stamp[i] = '0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part at reset settings; the block clears its rows first.
        // Bucket 5 is shared by the five ids below.
        pending_q.push_back(make_item(FUNC_TAINT, 32'h0, 32'hFFFF_FFFF, 64'd0));
        pending_q.push_back(make_item(FUNC_TAINT, 32'h4, 32'h0, 64'd0));
        pending_q.push_back(make_item(FUNC_QUERY, 32'h0, 32'h0, 64'd0));
        pending_q.push_back(make_item(FUNC_CLEAR, 32'h4, 32'h0, 64'd0));
        pending_q.push_back(make_item(FUNC_TAINT, 32'h0000_1014, 32'hFFFF_FFFF, 64'd0));
        pending_q.push_back(make_item(FUNC_TAINT, 32'h0000_1014, 32'h0, 64'd10));
        pending_q.push_back(make_item(FUNC_QUERY, 32'h0000_1014, 32'h0, 64'd20));
        pending_q.push_back(make_item(FUNC_TAINT, 32'h0000_2015, 32'h1, 64'd30));
        pending_q.push_back(make_item(FUNC_TAINT, 32'h0000_3016, 32'h2, 64'd30));
        pending_q.push_back(make_item(FUNC_TAINT, 32'h0000_4017, 32'h4, 64'd30));
        // bucket full: insert dropped
        pending_q.push_back(make_item(FUNC_TAINT, 32'h0000_5014, 32'h8, 64'd40));
        pending_q.push_back(make_item(FUNC_CLEAR, 32'h0000_3016, 32'h0, 64'd45));
        // freed way is reused
        pending_q.push_back(make_item(FUNC_TAINT, 32'h0000_5014, 32'h8, 64'd50));
        // age equal to the ttl is still live, one tick more expires
        pending_q.push_back(make_item(FUNC_QUERY, 32'h0000_1014, 32'h0,
                                      64'd10 + TTL_RESET));
        pending_q.push_back(make_item(FUNC_QUERY, 32'h0000_1014, 32'h0,
                                      64'd11 + TTL_RESET));
        pending_q.push_back(make_item(FUNC_QUERY, 32'h0000_1014, 32'h0,
                                      64'd12 + TTL_RESET));
        // taint of an expired entry refreshes it; age then wraps around zero
        pending_q.push_back(make_item(FUNC_TAINT, 32'h0000_4017, 32'h1,
                                      64'hFFFF_FFFF_FFFF_FFFF));
        pending_q.push_back(make_item(FUNC_QUERY, 32'h0000_4017, 32'h0, 64'd5));
        pending_q.push_back(make_item(FUNC_TAINT, 32'hFFFF_FFFF, 32'h0,
                                      64'hFFFF_FFFF_FFFF_FFFF));
        pending_q.push_back(make_item(FUNC_QUERY, 32'hFFFF_FFFF, 32'h0, 64'd0));
        pending_q.push_back(make_item(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                      64'hFFFF_FFFF_FFFF_FFFF));
        pending_q.push_back(make_item(FUNC_CLEAR, 32'hFFFF_FFFF, 32'h0, 64'd1));
        pending_q.push_back(make_item(FUNC_QUERY, 32'h0000_2015, 32'h0,
                                      64'h8000_0000_0000_0000));
        wait_all_results();

        // Short ttl, a pool id reserved, sender idling
        build_id_pool();
        write_reg(CFG_TTL, 64'd50);
        write_reg(CFG_RESERVED_A, 64'(id_pool[0]));
        write_reg(CFG_RESERVED_B, 64'h0000_0000_FFFF_FFFF);
        tick_now = 64'd1000;
        run_random(110, 46, 0, 64'd30);

        // Zero ttl near the top of the time range so the clock wraps; receiver stalls
        build_id_pool();
        write_reg(CFG_TTL, 64'd0);
        write_reg(CFG_RESERVED_A, 64'h0);
        write_reg(CFG_RESERVED_B, 64'(id_pool[$urandom_range(0, 9)]));
        tick_now = 64'hFFFF_FFFF_FFFF_FFE0;
        run_random(110, 0, 46, 64'd1);

        // Endless ttl, both sides idle
        build_id_pool();
        write_reg(CFG_TTL, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_RESERVED_A, 64'h0000_0000_FFFF_FFFF);
        write_reg(CFG_RESERVED_B, 64'(id_pool[$urandom_range(0, 9)]));
        tick_now = rand64();
        run_random(110, 30, 30, 64'h0000_0100_0000_0000);

        // Back to reset settings; hold the receiver off while beats keep coming
        // so the block backs up and drops s_ready, then release and drain.
        build_id_pool();
        write_reg(CFG_TTL, TTL_RESET);
        write_reg(CFG_RESERVED_A, 64'(RESERVED_A_RESET));
        write_reg(CFG_RESERVED_B, 64'(RESERVED_B_RESET));
        tick_now = 64'd0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        tick_step_max  = 64'd6_000_000_000;
        for (int n = 0; n < 60; n++) pending_q.push_back(random_item());
        hold_req <= 1'b1;
        @(posedge aclk);
        hold_req <= 1'b0;
        do @(negedge aclk); while (hold_left != 0);
        run_random(60, 0, 0, 64'd6_000_000_000);

        wait_all_results();
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
